// File: hw/rtl/cvwt_pkg.sv
// ----------------------------------------------------------------------------
// cvwt_pkg: shared types and constants of the commit visibility window tracker
// Event codes, reset values and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package cvwt_pkg;

	localparam int DEF_CORES        = 16;
	localparam int DEF_WINDOW_DEPTH = 256;

	localparam logic [63:0] ALL_ONES  = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [8:0]  THR_RESET = 9'd64;

	// event codes carried on mode
	localparam logic [2:0] MODE_CURSOR  = 3'd0;
	localparam logic [2:0] MODE_OLDEST  = 3'd1;
	localparam logic [2:0] MODE_SET_SNP = 3'd2;
	localparam logic [2:0] MODE_LOW_SNP = 3'd3;
	localparam logic [2:0] MODE_BEGIN   = 3'd4;
	localparam logic [2:0] MODE_END     = 3'd5;
	localparam logic [2:0] MODE_PUBLISH = 3'd6;
	localparam logic [2:0] MODE_LOOKUP  = 3'd7;

	// controller commands
	typedef struct packed {
		logic load;    // latch a new item, clear per-item accumulators
		logic event_c; // apply a per-core event
		logic find;    // window scan: id match and free entry
		logic insert;  // add the publish entry, raise the ceiling
		logic cscan;   // core scan: minima, candidate, attach count
		logic rinit;   // seed reach with the floor candidate
		logic reach;   // window scan: pin reach below entries above the horizon
		logic drop;    // window scan: drop entries below reach
		logic fin;     // raise floor, reload reclaim limit
	} cmd_t;

	// datapath status
	typedef struct packed {
		logic wlast;     // last cycle of a window scan
		logic clast;     // last cycle of a core scan
		logic is_pub;
		logic is_look;
		logic need_rc;   // window count reached the reclaim limit
		logic cand_ones; // floor candidate is all ones
		logic hor_ones;  // snapshot horizon is all ones
	} sts_t;

endpackage

// File: hw/rtl/cvwt_ctrl.sv
// ----------------------------------------------------------------------------
// cvwt_ctrl: sequencer of the commit visibility window tracker
// Walks each item through the event step and, as its mode needs, window scans,
// core scan and reclaim, and raises done for one cycle when the result is ready.
// ----------------------------------------------------------------------------
module cvwt_ctrl import cvwt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  sts_t sts,
	output cmd_t cmd,
	output logic busy,
	output logic done
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_EVENT  = 4'd1;
	localparam logic [3:0] S_FIND   = 4'd2;
	localparam logic [3:0] S_INSERT = 4'd3;
	localparam logic [3:0] S_CSCAN  = 4'd4;
	localparam logic [3:0] S_CHECK  = 4'd5;
	localparam logic [3:0] S_REACH  = 4'd6;
	localparam logic [3:0] S_DROP   = 4'd7;
	localparam logic [3:0] S_FIN    = 4'd8;
	localparam logic [3:0] S_DONE   = 4'd9;

	logic [3:0] state_q;
	logic [3:0] state_d;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_EVENT;
				end
			end
			S_EVENT: begin
				cmd.event_c = 1'b1;
				state_d     = (sts.is_pub || sts.is_look) ? S_FIND : S_CSCAN;
			end
			S_FIND: begin
				cmd.find = 1'b1;
				if (sts.wlast) state_d = sts.is_pub ? S_INSERT : S_CSCAN;
			end
			S_INSERT: begin
				cmd.insert = 1'b1;
				state_d    = S_CSCAN;
			end
			S_CSCAN: begin
				cmd.cscan = 1'b1;
				if (sts.clast) state_d = sts.is_pub ? S_CHECK : S_DONE;
			end
			S_CHECK: begin
				if (sts.need_rc && !sts.cand_ones) begin
					cmd.rinit = 1'b1;
					state_d   = sts.hor_ones ? S_DROP : S_REACH;
				end else begin
					state_d = S_DONE;
				end
			end
			S_REACH: begin
				cmd.reach = 1'b1;
				if (sts.wlast) state_d = S_DROP;
			end
			S_DROP: begin
				cmd.drop = 1'b1;
				if (sts.wlast) state_d = S_FIN;
			end
			S_FIN: begin
				cmd.fin = 1'b1;
				state_d = S_DONE;
			end
			S_DONE: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);

	a_start_taken: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (state_q == S_EVENT))
		else $error("accepted item did not enter the event step");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held for more than one cycle");

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("done raised while idle");

endmodule

// File: hw/rtl/cvwt_dp.sv
// ----------------------------------------------------------------------------
// cvwt_dp: datapath of the commit visibility window tracker
// Per-core registers, the commit window memory with its valid bits, the scan
// counters and accumulators, and the result fields.
// ----------------------------------------------------------------------------
module cvwt_dp import cvwt_pkg::*; #(
	parameter int CORES        = DEF_CORES,
	parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output sts_t        sts,
	input  logic [2:0]  mode,
	input  logic [3:0]  core,
	input  logic [63:0] value,
	input  logic [63:0] given_lsn,
	input  logic        assign_next,
	input  logic        cfg_we,
	input  logic [8:0]  cfg_wdata,
	output logic [63:0] result_lsn,
	output logic        found,
	output logic [63:0] floor_value,
	output logic [63:0] snapshot_ceiling,
	output logic        pins_floor,
	output logic [8:0]  dropped,
	output logic [8:0]  window_count,
	output logic [4:0]  attached_count,
	output logic        overflow
);

	localparam int CW   = (CORES > 1) ? $clog2(CORES) : 1;
	localparam int SW   = $clog2(CORES + 1);
	localparam int WW   = $clog2(WINDOW_DEPTH);
	localparam int CNTW = $clog2(WINDOW_DEPTH + 1);
	localparam int LW   = (CNTW + 1 > 9) ? CNTW + 1 : 9;

	// latched item
	logic [2:0]  mode_q;
	logic [3:0]  core_q;
	logic [63:0] value_q;
	logic [63:0] given_q;
	logic        assign_q;

	// per-core state
	logic [63:0] cur_q  [CORES];
	logic [63:0] old_q  [CORES];
	logic [63:0] snap_q [CORES];
	logic [63:0] pend_q [CORES];
	logic [SW-1:0] slots_q;

	// global state
	logic [63:0]     ceil_q;
	logic [63:0]     floor_q;
	logic [8:0]      thr_q;
	logic [LW-1:0]   limit_q;
	logic [CNTW-1:0] count_q;

	// commit window
	logic [127:0] mem [WINDOW_DEPTH];
	logic         wvalid_q [WINDOW_DEPTH];

	// window scan pipeline
	logic [WW:0]    widx_q;
	logic           rd_v_s1;
	logic           valid_s1;
	logic [WW-1:0]  ridx_s1;
	logic [127:0]   rdata_s1;

	// per-item accumulators
	logic            present_q;
	logic            found_q;
	logic [63:0]     flsn_q;
	logic            free_ok_q;
	logic [WW-1:0]   free_idx_q;
	logic [63:0]     res_lsn_q;
	logic            ovf_q;
	logic [SW-1:0]   cidx_q;
	logic [63:0]     pmin_q;
	logic [63:0]     smin_q;
	logic [63:0]     cand_q;
	logic [SW-1:0]   att_q;
	logic [63:0]     curc_q;
	logic [63:0]     reach_q;
	logic [CNTW-1:0] dropcnt_q;

	logic          core_ok;
	logic [CW-1:0] core_idx;
	logic [CW-1:0] caddr;
	logic [SW-1:0] slot_new;
	logic          note;
	logic          scan;
	logic          scan_rd;
	logic          wlast;
	logic [WW-1:0] waddr;
	logic          hit_v;
	logic [63:0]   id_s1;
	logic [63:0]   lsn_s1;
	logic [63:0]   lsn_new;
	logic          ins_ok;
	logic          cproc;
	logic          clast;
	logic [63:0]   horizon;
	logic [63:0]   c_cur;
	logic [63:0]   c_old;
	logic [63:0]   c_snap;
	logic [63:0]   c_pend;
	logic [63:0]   cand_a;
	logic [LW-1:0] twice;
	logic [LW-1:0] thr_ext;

	assign core_ok  = (32'(core_q) < CORES);
	assign core_idx = CW'(core_q);
	assign caddr    = cmd.cscan ? cidx_q[CW-1:0] : core_idx;
	assign slot_new = SW'(core_q) + SW'(1);
	assign c_cur    = cur_q[caddr];
	assign c_old    = old_q[caddr];
	assign c_snap   = snap_q[caddr];
	assign c_pend   = pend_q[caddr];

	assign scan    = cmd.find || cmd.reach || cmd.drop;
	assign scan_rd = scan && (32'(widx_q) < WINDOW_DEPTH);
	assign wlast   = (32'(widx_q) == WINDOW_DEPTH);
	assign waddr   = widx_q[WW-1:0];
	assign hit_v   = rd_v_s1 && valid_s1;
	assign id_s1   = rdata_s1[127:64];
	assign lsn_s1  = rdata_s1[63:0];
	assign lsn_new = assign_q ? ceil_q + 64'd1 : given_q;
	assign ins_ok  = !present_q && free_ok_q;

	assign cproc   = cmd.cscan && (cidx_q < slots_q);
	assign clast   = ({1'b0, cidx_q} + {{SW{1'b0}}, 1'b1}) >= {1'b0, slots_q};
	assign horizon = (pmin_q < smin_q) ? pmin_q : smin_q;
	assign twice   = LW'({count_q, 1'b0});
	assign thr_ext = LW'(thr_q);

	// pick the smaller of cursor and oldest id for an attached core
	always_comb begin
		cand_a = cand_q;
		if (c_cur < cand_a) cand_a = c_cur;
		if (c_old < cand_a) cand_a = c_old;
	end

	// slot note for modes that claim a core
	always_comb begin
		note = 1'b0;
		if (cmd.event_c && core_ok) begin
			case (mode_q)
				MODE_CURSOR:
					note = !(c_cur != ALL_ONES && value_q <= c_cur);
				MODE_OLDEST, MODE_SET_SNP, MODE_LOW_SNP, MODE_BEGIN:
					note = 1'b1;
				default:
					note = 1'b0;
			endcase
		end
	end

	// latch the item
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q   <= mode;
			core_q   <= core;
			value_q  <= value;
			given_q  <= given_lsn;
			assign_q <= assign_next;
		end
	end

	// apply per-core events
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CORES; i++) begin
				cur_q[i]  <= ALL_ONES;
				old_q[i]  <= ALL_ONES;
				snap_q[i] <= ALL_ONES;
				pend_q[i] <= ALL_ONES;
			end
			slots_q <= '0;
		end else if (cmd.event_c && core_ok) begin
			case (mode_q)
				MODE_CURSOR: if (note) cur_q[core_idx] <= value_q;
				MODE_OLDEST: old_q[core_idx] <= value_q;
				MODE_SET_SNP: snap_q[core_idx] <= value_q;
				MODE_LOW_SNP: if (value_q < c_snap) snap_q[core_idx] <= value_q;
				MODE_BEGIN: pend_q[core_idx] <= ceil_q;
				MODE_END: pend_q[core_idx] <= ALL_ONES;
				default: ;
			endcase
			if (note && slots_q < slot_new) slots_q <= slot_new;
		end
	end

	// window memory: insert port and scan read port
	always_ff @(posedge clk) begin
		if (cmd.insert && ins_ok) mem[free_idx_q] <= {value_q, lsn_new};
		if (scan_rd) rdata_s1 <= mem[waddr];
	end

	// valid bits: set on insert, clear on drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW_DEPTH; i++) wvalid_q[i] <= 1'b0;
		end else begin
			if (cmd.insert && ins_ok) wvalid_q[free_idx_q] <= 1'b1;
			if (cmd.drop && hit_v && id_s1 < reach_q) wvalid_q[ridx_s1] <= 1'b0;
		end
	end

	// advance the window scan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			widx_q  <= '0;
			rd_v_s1 <= 1'b0;
		end else begin
			widx_q  <= (scan && !wlast) ? widx_q + (WW+1)'(1) : '0;
			rd_v_s1 <= scan_rd;
		end
	end

	always_ff @(posedge clk) begin
		valid_s1 <= wvalid_q[waddr];
		ridx_s1  <= waddr;
	end

	// global registers and item accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ceil_q    <= '0;
			floor_q   <= '0;
			thr_q     <= THR_RESET;
			limit_q   <= LW'(THR_RESET);
			count_q   <= '0;
			cidx_q    <= '0;
			present_q <= 1'b0;
			found_q   <= 1'b0;
			free_ok_q <= 1'b0;
			ovf_q     <= 1'b0;
			att_q     <= '0;
			dropcnt_q <= '0;
		end else begin
			if (cfg_we) begin
				thr_q   <= cfg_wdata;
				limit_q <= LW'(cfg_wdata);
			end
			cidx_q <= (cmd.cscan && !clast) ? cidx_q + SW'(1) : '0;
			if (cmd.load) begin
				present_q <= 1'b0;
				found_q   <= 1'b0;
				free_ok_q <= 1'b0;
				ovf_q     <= 1'b0;
				att_q     <= '0;
				dropcnt_q <= '0;
				pmin_q    <= ALL_ONES;
				smin_q    <= ALL_ONES;
				cand_q    <= ALL_ONES;
				curc_q    <= ALL_ONES;
				res_lsn_q <= '0;
			end
			// id match and first free entry
			if (cmd.find) begin
				if (hit_v && id_s1 == value_q) begin
					present_q <= 1'b1;
					if (!found_q) begin
						found_q <= 1'b1;
						flsn_q  <= lsn_s1;
					end
				end
				if (rd_v_s1 && !valid_s1 && !free_ok_q) begin
					free_ok_q  <= 1'b1;
					free_idx_q <= ridx_s1;
				end
			end
			// add the entry or flag a full window
			if (cmd.insert) begin
				res_lsn_q <= lsn_new;
				if (!present_q && !free_ok_q) begin
					ovf_q <= 1'b1;
				end else begin
					if (!present_q) count_q <= count_q + CNTW'(1);
					if (lsn_new > ceil_q) ceil_q <= lsn_new;
				end
			end
			// fold one core into the minima
			if (cproc) begin
				if (c_pend < pmin_q) pmin_q <= c_pend;
				if (c_snap < smin_q) smin_q <= c_snap;
				if (c_cur != ALL_ONES) begin
					att_q  <= att_q + SW'(1);
					cand_q <= cand_a;
				end
				if (core_ok && cidx_q[CW-1:0] == core_idx) curc_q <= c_cur;
			end
			if (cmd.rinit) reach_q <= cand_q;
			// pin reach below entries above the horizon
			if (cmd.reach && hit_v && id_s1 < reach_q && lsn_s1 > horizon)
				reach_q <= id_s1;
			// drop entries below reach
			if (cmd.drop && hit_v && id_s1 < reach_q) begin
				dropcnt_q <= dropcnt_q + CNTW'(1);
				count_q   <= count_q - CNTW'(1);
			end
			// raise floor, reload limit
			if (cmd.fin) begin
				if (reach_q > floor_q) floor_q <= reach_q;
				limit_q <= (twice > thr_ext) ? twice : thr_ext;
			end
		end
	end

	// status
	assign sts.wlast     = wlast;
	assign sts.clast     = clast;
	assign sts.is_pub    = (mode_q == MODE_PUBLISH);
	assign sts.is_look   = (mode_q == MODE_LOOKUP);
	assign sts.need_rc   = (LW'(count_q) >= limit_q);
	assign sts.cand_ones = (cand_q == ALL_ONES);
	assign sts.hor_ones  = (horizon == ALL_ONES);

	// result fields
	always_comb begin
		result_lsn = '0;
		if (mode_q == MODE_PUBLISH) result_lsn = res_lsn_q;
		else if (mode_q == MODE_LOOKUP && found_q) result_lsn = flsn_q;
	end

	assign found            = (mode_q == MODE_LOOKUP) && found_q;
	assign floor_value      = floor_q;
	assign snapshot_ceiling = (pmin_q < ceil_q) ? pmin_q : ceil_q;
	assign pins_floor       = core_ok && (curc_q != ALL_ONES) && (32'(att_q) >= 2)
		&& (curc_q == cand_q);
	assign dropped          = 9'(dropcnt_q);
	assign window_count     = 9'(count_q);
	assign attached_count   = 5'(att_q);
	assign overflow         = ovf_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= WINDOW_DEPTH)
		else $error("window count above depth");

	a_floor_mono: assert property (@(posedge clk) disable iff (!arst_n)
		floor_q >= $past(floor_q))
		else $error("reclamation floor went down");

	a_slots_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(slots_q) <= CORES)
		else $error("slot count above core count");

endmodule

// File: hw/rtl/commit_visibility_window_tracker_top.sv
// ----------------------------------------------------------------------------
// commit_visibility_window_tracker_top: commit visibility window tracker
// Per-core cursors and snapshot bounds plus a window of committed ids, with
// commit publish, lookup and floor reclamation.
// ----------------------------------------------------------------------------
// Usage:
//   Drive mode, core, value, given_lsn and assign_next with start high; the
//   item is taken at a clock edge where busy is low. busy stays high until
//   the result, which shows on the result ports for one cycle with done.
//   The receiver cannot stall; capture the result while done is high.
//   cfg_we with cfg_wdata loads the reclaim threshold and the reclaim limit;
//   write it only while busy is low.
//   A publish runs a reclaim when the window count has reached the reclaim
//   limit and the floor candidate is not all ones; the reclaim skips the
//   reach scan when the snapshot horizon is all ones. The window scans
//   read every entry through the single read port of the window memory,
//   one entry per cycle; the core scan takes one in-use core slot per cycle.
//   Reset clears all core state to all ones, the window valid bits, counts,
//   ceiling and floor, and loads a threshold of 64; no clearing pass.
// ----------------------------------------------------------------------------
module commit_visibility_window_tracker_top import cvwt_pkg::*; #(
	parameter int CORES        = DEF_CORES,
	parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  mode,
	input  logic [3:0]  core,
	input  logic [63:0] value,
	input  logic [63:0] given_lsn,
	input  logic        assign_next,
	input  logic        cfg_we,
	input  logic [8:0]  cfg_wdata,
	output logic        done,
	output logic [63:0] result_lsn,
	output logic        found,
	output logic [63:0] floor_value,
	output logic [63:0] snapshot_ceiling,
	output logic        pins_floor,
	output logic [8:0]  dropped,
	output logic [8:0]  window_count,
	output logic [4:0]  attached_count,
	output logic        overflow
);

	cmd_t cmd;
	sts_t sts;
	logic ctl_busy;

	// sequencer
	cvwt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (ctl_busy),
		.done   (done)
	);

	// state and window
	cvwt_dp #(
		.CORES        (CORES),
		.WINDOW_DEPTH (WINDOW_DEPTH)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.mode             (mode),
		.core             (core),
		.value            (value),
		.given_lsn        (given_lsn),
		.assign_next      (assign_next),
		.cfg_we           (cfg_we),
		.cfg_wdata        (cfg_wdata),
		.result_lsn       (result_lsn),
		.found            (found),
		.floor_value      (floor_value),
		.snapshot_ceiling (snapshot_ceiling),
		.pins_floor       (pins_floor),
		.dropped          (dropped),
		.window_count     (window_count),
		.attached_count   (attached_count),
		.overflow         (overflow)
	);

	assign busy = ctl_busy;

endmodule
